### rtl/core/skc_pkg.sv
package skc_pkg;

	localparam int OUT_FRAC = 22;
	localparam int OUT_W    = 23;
	localparam int MAG_W    = 23;
	localparam int AMOUNT_W = 17;
	localparam int K_W      = 22;
	localparam int KN_W     = 26;
	localparam int K_SHIFT  = 29;
	localparam int Q1_W     = 23;
	localparam int Q2_W     = 22;
	localparam int DEN2_W   = 24;
	localparam int Y_W      = 24;
	localparam int CAP_W    = 22;

	localparam logic [MAG_W-1:0]    ONE22      = 23'd4194304;
	localparam logic [CAP_W-1:0]    CEIL22     = 22'd4146489;
	localparam logic [AMOUNT_W-1:0] AMOUNT_ONE = 17'd65536;
	localparam logic [KN_W-1:0]     K_SCALE    = 26'd576;
	localparam logic [KN_W-1:0]     K_ROUND    = 26'd5;
	localparam logic [KN_W-1:0]     K_RECIP    = 26'd53687092;
	localparam logic [K_W-1:0]      K_MAX      = 22'd3774874;

	typedef struct packed {
		logic             neg;
		logic             knee;
		logic [MAG_W-1:0] ax;
	} skc_base_t;

	typedef struct packed {
		skc_base_t      base;
		logic [K_W-1:0] o;
	} skc_side1_t;

endpackage

### rtl/core/skc_if.sv
interface skc_dry_if #(parameter int SAMPLE_WIDTH = 24);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface skc_wet_if;
	logic                              valid;
	logic                              ready;
	logic signed [skc_pkg::OUT_W-1:0] sample_out;
	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

interface skc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [skc_pkg::AMOUNT_W-1:0] amount;
	modport source (output valid, output amount, input ready);
	modport sink (input valid, input amount, output ready);
endinterface

### rtl/core/skc_front.sv
module skc_front #(
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        en,
	input  logic                                        in_valid,
	input  logic signed [SAMPLE_WIDTH-1:0]              sample_in,
	input  logic [skc_pkg::K_W-1:0]                     k,
	output logic                                        out_valid,
	output logic [skc_pkg::Q1_W+skc_pkg::K_W-1:0]       num,
	output skc_pkg::skc_side1_t                         side
);

	localparam int FRAC = SAMPLE_WIDTH - 4;
	localparam int CL_W = FRAC + 1;
	localparam logic [SAMPLE_WIDTH-1:0] ONE_IN = SAMPLE_WIDTH'(1) << FRAC;

	logic [SAMPLE_WIDTH-1:0]        raw;
	logic [SAMPLE_WIDTH-1:0]        mag;
	logic [CL_W-1:0]                mag_cl;
	logic [skc_pkg::MAG_W-1:0]      ax_c;
	logic [skc_pkg::MAG_W:0]        sum;
	logic                           knee;

	logic                           v_s1;
	logic                           neg_s1;
	logic [skc_pkg::MAG_W-1:0]      ax_s1;
	logic                           v_s2;
	logic [skc_pkg::Q1_W+skc_pkg::K_W-1:0] num_s2;
	skc_pkg::skc_side1_t            side_s2;

	assign raw    = sample_in;
	assign mag    = raw[SAMPLE_WIDTH-1] ? (~raw + SAMPLE_WIDTH'(1)) : raw;
	assign mag_cl = (mag > ONE_IN) ? ONE_IN[CL_W-1:0] : mag[CL_W-1:0];

	// align the clamped magnitude to q22
	if (FRAC <= skc_pkg::OUT_FRAC) begin : g_up
		assign ax_c = skc_pkg::MAG_W'(mag_cl) << (skc_pkg::OUT_FRAC - FRAC);
	end else begin : g_down
		assign ax_c = skc_pkg::MAG_W'(mag_cl >> (FRAC - skc_pkg::OUT_FRAC));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= raw[SAMPLE_WIDTH-1];
			ax_s1  <= ax_c;
		end
	end

	// ax > 1 - k  <=>  ax + k > 1, excess is the low bits of the sum
	assign sum  = {1'b0, ax_s1} + (skc_pkg::MAG_W+1)'(k);
	assign knee = (k != '0) && (sum > {1'b0, skc_pkg::ONE22});

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.base.neg  <= neg_s1;
			side_s2.base.knee <= knee;
			side_s2.base.ax   <= ax_s1;
			side_s2.o         <= sum[skc_pkg::K_W-1:0];
			num_s2            <= {1'b0, sum[skc_pkg::K_W-1:0], 1'b0, k[skc_pkg::K_W-1:1]};
		end
	end

	assign out_valid = v_s2;
	assign num       = num_s2;
	assign side      = side_s2;

endmodule

### rtl/core/skc_div.sv
module skc_div #(
	parameter int QUO_W = 23,
	parameter int DEN_W = 22,
	parameter type side_t = logic
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [QUO_W+DEN_W-1:0] num,
	input  logic [DEN_W-1:0]       den,
	input  side_t                  in_side,
	output logic                   out_valid,
	output logic [QUO_W-1:0]       quo,
	output side_t                  out_side
);

	// one quotient bit per stage, numerator low bits shift out as quotient bits shift in
	logic             v_s    [QUO_W];
	logic [QUO_W-1:0] lo_s   [QUO_W];
	side_t            side_s [QUO_W];
	logic [DEN_W-1:0] rem_s  [QUO_W-1];
	logic [DEN_W-1:0] den_s  [QUO_W-1];

	for (genvar j = 0; j < QUO_W; j++) begin : g_stage
		logic             v_i;
		logic [DEN_W-1:0] rem_i;
		logic [DEN_W-1:0] den_i;
		logic [QUO_W-1:0] lo_i;
		side_t            side_i;
		logic [DEN_W:0]   sh;
		logic             ge;

		if (j == 0) begin : g_first
			assign v_i    = in_valid;
			assign rem_i  = num[QUO_W+DEN_W-1:QUO_W];
			assign den_i  = den;
			assign lo_i   = num[QUO_W-1:0];
			assign side_i = in_side;
		end else begin : g_next
			assign v_i    = v_s[j-1];
			assign rem_i  = rem_s[j-1];
			assign den_i  = den_s[j-1];
			assign lo_i   = lo_s[j-1];
			assign side_i = side_s[j-1];
		end

		assign sh = {rem_i, lo_i[QUO_W-1]};
		assign ge = sh >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lo_s[j]   <= QUO_W'({lo_i, ge});
				side_s[j] <= side_i;
			end
		end

		if (j < QUO_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= ge ? DEN_W'(sh - {1'b0, den_i}) : sh[DEN_W-1:0];
					den_s[j] <= den_i;
				end
			end
		end
	end

	assign out_valid = v_s[QUO_W-1];
	assign quo       = lo_s[QUO_W-1];
	assign out_side  = side_s[QUO_W-1];

endmodule

### rtl/core/skc_square.sv
module skc_square (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       en,
	input  logic                                       in_valid,
	input  logic [skc_pkg::Q1_W-1:0]                   q,
	input  skc_pkg::skc_side1_t                        in_side,
	output logic                                       out_valid,
	output logic [skc_pkg::Q2_W+skc_pkg::DEN2_W-1:0]   num,
	output logic [skc_pkg::DEN2_W-1:0]                 den,
	output skc_pkg::skc_base_t                         out_side
);

	localparam int P_W   = 2 * skc_pkg::Q1_W;
	localparam int NUM_W = skc_pkg::Q2_W + skc_pkg::DEN2_W;
	localparam logic [P_W-1:0]   P_HALF = P_W'(1) << (skc_pkg::OUT_FRAC - 1);
	localparam logic [NUM_W-1:0] D_HALF = NUM_W'(1) << (skc_pkg::OUT_FRAC - 1);

	logic                       v_s1;
	logic                       v_s2;
	logic                       v_s3;
	logic [P_W-1:0]             prod_s1;
	logic [skc_pkg::MAG_W-1:0]  qq_s2;
	skc_pkg::skc_side1_t        side_s1;
	skc_pkg::skc_side1_t        side_s2;
	skc_pkg::skc_base_t         base_s3;
	logic [skc_pkg::DEN2_W-1:0] den_s3;
	logic [NUM_W-1:0]           num_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= P_W'(q) * P_W'(q);
			side_s1 <= in_side;
			qq_s2   <= skc_pkg::MAG_W'((prod_s1 + P_HALF) >> skc_pkg::OUT_FRAC);
			side_s2 <= side_s1;
			// den = 1 + qq, numerator carries half of den for rounding
			den_s3  <= skc_pkg::DEN2_W'(skc_pkg::ONE22) + skc_pkg::DEN2_W'(qq_s2);
			num_s3  <= NUM_W'({side_s2.o, skc_pkg::OUT_FRAC'(0)}) + NUM_W'(qq_s2 >> 1)
				+ D_HALF;
			base_s3 <= side_s2.base;
		end
	end

	assign out_valid = v_s3;
	assign num       = num_s3;
	assign den       = den_s3;
	assign out_side  = base_s3;

endmodule

### rtl/core/skc_back.sv
module skc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [skc_pkg::Q2_W-1:0]    d,
	input  skc_pkg::skc_base_t          in_side,
	input  logic [skc_pkg::K_W-1:0]     k,
	output logic                        out_valid,
	output logic                        neg,
	output logic [skc_pkg::CAP_W-1:0]   y
);

	logic                      v_s1;
	logic                      v_s2;
	logic                      neg_s1;
	logic                      neg_s2;
	logic [skc_pkg::Y_W-1:0]   y_s1;
	logic [skc_pkg::CAP_W-1:0] y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= in_side.neg;
			// threshold plus compressed excess above the knee, the plain magnitude below it
			y_s1   <= in_side.knee
				? skc_pkg::Y_W'(skc_pkg::ONE22) - skc_pkg::Y_W'(k) + skc_pkg::Y_W'(d)
				: skc_pkg::Y_W'(in_side.ax);
			neg_s2 <= neg_s1;
			y_s2   <= (y_s1 > skc_pkg::Y_W'(skc_pkg::CEIL22))
				? skc_pkg::CEIL22 : y_s1[skc_pkg::CAP_W-1:0];
		end
	end

	assign out_valid = v_s2;
	assign neg       = neg_s2;
	assign y         = y_s2;

endmodule

### rtl/core/soft_knee_clip_curve_unit.sv
// throughput: one beat per cycle while the output is not stalled, set by the bit-per-stage dividers (23 and 22 stages)
// a stalled output freezes the pipeline once the one-entry skid register is full
// reset clears all valid bits and sets amount to zero; no clearing pass
module soft_knee_clip_curve_unit #(
	parameter int SAMPLE_WIDTH = 24
) (
	input logic        clk,
	input logic        arst_n,
	skc_cfg_if.sink    cfg,
	skc_dry_if.sink    dry,
	skc_wet_if.source  wet
);

	localparam int NUM1_W = skc_pkg::Q1_W + skc_pkg::K_W;
	localparam int NUM2_W = skc_pkg::Q2_W + skc_pkg::DEN2_W;

	logic [skc_pkg::AMOUNT_W-1:0] amt_sat;
	logic [skc_pkg::KN_W-1:0]     kn_q;
	logic [2*skc_pkg::KN_W-1:0]   kprod;
	logic [skc_pkg::K_W-1:0]      k_q;

	logic                         en;
	logic                         fr_valid;
	logic [NUM1_W-1:0]            fr_num;
	skc_pkg::skc_side1_t          fr_side;
	logic                         d1_valid;
	logic [skc_pkg::Q1_W-1:0]     d1_quo;
	skc_pkg::skc_side1_t          d1_side;
	logic                         sq_valid;
	logic [NUM2_W-1:0]            sq_num;
	logic [skc_pkg::DEN2_W-1:0]   sq_den;
	skc_pkg::skc_base_t           sq_side;
	logic                         d2_valid;
	logic [skc_pkg::Q2_W-1:0]     d2_quo;
	skc_pkg::skc_base_t           d2_side;
	logic                         bk_valid;
	logic                         bk_neg;
	logic [skc_pkg::CAP_W-1:0]    bk_y;

	logic [skc_pkg::OUT_W-1:0]    res;
	logic                         pop;
	logic                         ov_q;
	logic                         sk_v_q;
	logic [skc_pkg::OUT_W-1:0]    out_d_q;
	logic [skc_pkg::OUT_W-1:0]    sk_d_q;

	// knee width k = round(amount * 0.9 * 2^6), divide by ten through a reciprocal
	assign cfg.ready = 1'b1;
	assign amt_sat   = (cfg.amount > skc_pkg::AMOUNT_ONE) ? skc_pkg::AMOUNT_ONE : cfg.amount;
	assign kprod     = (2*skc_pkg::KN_W)'(kn_q) * (2*skc_pkg::KN_W)'(skc_pkg::K_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kn_q <= skc_pkg::K_ROUND;
			k_q  <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				kn_q <= skc_pkg::KN_W'(amt_sat) * skc_pkg::K_SCALE + skc_pkg::K_ROUND;
			end
			k_q <= kprod[skc_pkg::K_SHIFT +: skc_pkg::K_W];
		end
	end

	assign en        = !sk_v_q;
	assign dry.ready = en;

	skc_front #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dry.valid),
		.sample_in (dry.sample_in),
		.k         (k_q),
		.out_valid (fr_valid),
		.num       (fr_num),
		.side      (fr_side)
	);

	skc_div #(
		.QUO_W  (skc_pkg::Q1_W),
		.DEN_W  (skc_pkg::K_W),
		.side_t (skc_pkg::skc_side1_t)
	) u_div_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.num       (fr_num),
		.den       (k_q),
		.in_side   (fr_side),
		.out_valid (d1_valid),
		.quo       (d1_quo),
		.out_side  (d1_side)
	);

	skc_square u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d1_valid),
		.q         (d1_quo),
		.in_side   (d1_side),
		.out_valid (sq_valid),
		.num       (sq_num),
		.den       (sq_den),
		.out_side  (sq_side)
	);

	skc_div #(
		.QUO_W  (skc_pkg::Q2_W),
		.DEN_W  (skc_pkg::DEN2_W),
		.side_t (skc_pkg::skc_base_t)
	) u_div_knee (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.num       (sq_num),
		.den       (sq_den),
		.in_side   (sq_side),
		.out_valid (d2_valid),
		.quo       (d2_quo),
		.out_side  (d2_side)
	);

	skc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d2_valid),
		.d         (d2_quo),
		.in_side   (d2_side),
		.k         (k_q),
		.out_valid (bk_valid),
		.neg       (bk_neg),
		.y         (bk_y)
	);

	// sign restore, then output register with one skid entry behind it
	assign res = bk_neg ? (skc_pkg::OUT_W'(0) - skc_pkg::OUT_W'(bk_y)) : skc_pkg::OUT_W'(bk_y);
	assign pop = ov_q && wet.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (sk_v_q) begin
			if (pop) begin
				sk_v_q <= 1'b0;
			end
		end else if (!ov_q || pop) begin
			ov_q <= bk_valid;
		end else if (bk_valid) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (pop) begin
				out_d_q <= sk_d_q;
			end
		end else if (!ov_q || pop) begin
			out_d_q <= res;
		end else begin
			sk_d_q <= res;
		end
	end

	assign wet.valid      = ov_q;
	assign wet.sample_out = out_d_q;

`ifndef ASSERT_OFF
	a_out_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (out_d_q[skc_pkg::OUT_W-1]
			? ((skc_pkg::OUT_W'(0) - out_d_q) <= skc_pkg::OUT_W'(skc_pkg::CEIL22))
			: (out_d_q <= skc_pkg::OUT_W'(skc_pkg::CEIL22))))
		else $error("output beat above the ceiling");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> ov_q)
		else $error("skid entry held with empty output register");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(ov_q && !wet.ready && bk_valid))
		else $error("skid filled without an output stall");

	a_knee_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= skc_pkg::K_MAX)
		else $error("knee width out of range");
`endif

endmodule
